@@ hw/rtl/bm_pkg.sv @@
package bm_pkg;

    // Field and state widths
    localparam int MV_W    = 15;
    localparam int SUM_W   = 20;
    localparam int CNT_W   = 6;
    localparam int DIV_W   = 4;
    localparam int BLINK_W = 10;
    localparam int TICK_W  = 8;
    localparam int TOG_W   = 4;

    // Averaging window
    localparam int SAMPLES_PER_AVERAGE = 50;
    localparam logic [CNT_W-1:0] SPA_CNT = CNT_W'(SAMPLES_PER_AVERAGE);

    // Divide by the window via reciprocal multiply: floor(x * RECIP / 2^RECIP_SHIFT).
    // Exact for every 20-bit sum and any window of 1..63.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
    localparam int PROD_W = SUM_W + RECIP_W;

    // Saturation limits
    localparam logic [DIV_W-1:0]   DIV_MAX   = '1;
    localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

    // Register file
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_LOW_THRESHOLD     = 3'd0,
        REG_SAMPLE_PERIOD     = 3'd1,
        REG_WAIT_TICKS        = 3'd2,
        REG_TOGGLE_TICKS      = 3'd3,
        REG_TOGGLES_PER_BURST = 3'd4
    } t_reg_idx;

    localparam logic [MV_W-1:0]    RST_LOW_THRESHOLD     = MV_W'(9600);
    localparam logic [DIV_W-1:0]   RST_SAMPLE_PERIOD     = DIV_W'(3);
    localparam logic [BLINK_W-1:0] RST_WAIT_TICKS        = BLINK_W'(300);
    localparam logic [TICK_W-1:0]  RST_TOGGLE_TICKS      = TICK_W'(20);
    localparam logic [TOG_W-1:0]   RST_TOGGLES_PER_BURST = TOG_W'(6);

    typedef struct packed {
        logic [MV_W-1:0]    low_threshold_mv;
        logic [DIV_W-1:0]   sample_period;
        logic [BLINK_W-1:0] wait_ticks;
        logic [TICK_W-1:0]  toggle_ticks;
        logic [TOG_W-1:0]   toggles_per_burst;
    } t_cfg;

    // Monitor status for the current tick, as seen by the blink sequencer
    typedef struct packed {
        logic            avg_ready;
        logic            alarm;
        logic            silence;
        logic [MV_W-1:0] average_mv;
    } t_mon_stat;

endpackage

@@ hw/rtl/bm_tick_if.sv @@
interface bm_tick_if;
    import bm_pkg::*;

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] battery_mv;

    modport source (output valid, output battery_mv, input ready);
    modport sink   (input valid, input battery_mv, output ready);
endinterface

@@ hw/rtl/bm_result_if.sv @@
interface bm_result_if;
    import bm_pkg::*;

    logic            valid;
    logic            ready;
    logic            led_on;
    logic            buzzer_on;
    logic            low_voltage;
    logic [MV_W-1:0] average_mv;
    logic            average_ready;

    modport source (
        output valid, output led_on, output buzzer_on, output low_voltage,
        output average_mv, output average_ready, input ready
    );
    modport sink (
        input valid, input led_on, input buzzer_on, input low_voltage,
        input average_mv, input average_ready, output ready
    );
endinterface

@@ hw/rtl/bm_regs.sv @@
module bm_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bm_pkg::PADDR_W-1:0]   paddr,
    input  logic [bm_pkg::PDATA_W-1:0]   pwdata,
    output logic [bm_pkg::PDATA_W-1:0]   prdata,
    output logic                         pready,
    output bm_pkg::t_cfg                 o_cfg
);
    import bm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold_mv  <= RST_LOW_THRESHOLD;
            r_cfg.sample_period     <= RST_SAMPLE_PERIOD;
            r_cfg.wait_ticks        <= RST_WAIT_TICKS;
            r_cfg.toggle_ticks      <= RST_TOGGLE_TICKS;
            r_cfg.toggles_per_burst <= RST_TOGGLES_PER_BURST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LOW_THRESHOLD:     r_cfg.low_threshold_mv  <= pwdata[MV_W-1:0];
                REG_SAMPLE_PERIOD:     r_cfg.sample_period     <= pwdata[DIV_W-1:0];
                REG_WAIT_TICKS:        r_cfg.wait_ticks        <= pwdata[BLINK_W-1:0];
                REG_TOGGLE_TICKS:      r_cfg.toggle_ticks      <= pwdata[TICK_W-1:0];
                REG_TOGGLES_PER_BURST: r_cfg.toggles_per_burst <= pwdata[TOG_W-1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (w_idx)
            REG_LOW_THRESHOLD:     prdata = PDATA_W'(r_cfg.low_threshold_mv);
            REG_SAMPLE_PERIOD:     prdata = PDATA_W'(r_cfg.sample_period);
            REG_WAIT_TICKS:        prdata = PDATA_W'(r_cfg.wait_ticks);
            REG_TOGGLE_TICKS:      prdata = PDATA_W'(r_cfg.toggle_ticks);
            REG_TOGGLES_PER_BURST: prdata = PDATA_W'(r_cfg.toggles_per_burst);
            default:               prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/bm_monitor.sv @@
module bm_monitor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [bm_pkg::MV_W-1:0]   i_mv,
    input  bm_pkg::t_cfg              i_cfg,
    output bm_pkg::t_mon_stat         o_stat
);
    import bm_pkg::*;

    logic [DIV_W-1:0] r_div,   n_div;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum,   n_sum;
    logic [MV_W-1:0]  r_avg,   n_avg;
    logic             r_alarm, n_alarm;

    logic [DIV_W-1:0]  w_div_inc;
    logic              w_take;
    logic [CNT_W-1:0]  w_count_inc;
    logic              w_done;
    logic [SUM_W:0]    w_sum_ext;
    logic [SUM_W-1:0]  w_sum_sat;
    logic [PROD_W-1:0] w_prod;
    logic [MV_W-1:0]   w_quot;
    logic              w_below;

    // Sample divider and saturating sum
    assign w_div_inc   = (r_div == DIV_MAX) ? r_div : r_div + DIV_W'(1);
    assign w_take      = (w_div_inc >= i_cfg.sample_period);
    assign w_count_inc = r_count + CNT_W'(1);
    assign w_done      = w_take && (w_count_inc == SPA_CNT);
    assign w_sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(i_mv);
    assign w_sum_sat   = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];

    // Average by reciprocal multiply, then threshold compare
    assign w_prod  = PROD_W'(w_sum_sat) * PROD_W'(RECIP);
    assign w_quot  = w_prod[RECIP_SHIFT +: MV_W];
    assign w_below = (w_quot < i_cfg.low_threshold_mv);

    // Next state
    always_comb begin
        n_div   = w_take ? '0 : w_div_inc;
        n_count = r_count;
        n_sum   = r_sum;
        n_avg   = r_avg;
        n_alarm = r_alarm;
        if (w_take) begin
            n_count = w_done ? '0 : w_count_inc;
            n_sum   = w_done ? '0 : w_sum_sat;
        end
        if (w_done) begin
            n_avg   = w_quot;
            n_alarm = w_below;
        end
    end

    always_comb begin
        o_stat.avg_ready  = w_done;
        o_stat.alarm      = n_alarm;
        o_stat.silence    = w_done && !w_below && r_alarm;
        o_stat.average_mv = n_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_avg   <= '0;
            r_alarm <= 1'b0;
        end else if (i_step) begin
            r_div   <= n_div;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_avg   <= n_avg;
            r_alarm <= n_alarm;
        end
    end

    // Sample count never reaches the window length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < SPA_CNT)
        else $error("sample count out of range");

    // Sum is cleared whenever an average completes
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_done |=> r_sum == '0)
        else $error("sum not cleared after average");

    // Alarm only drops on a completed average
    a_alarm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm && !(i_step && w_done) |=> r_alarm)
        else $error("alarm cleared without an average");

endmodule

@@ hw/rtl/bm_blink.sv @@
module bm_blink (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  bm_pkg::t_cfg       i_cfg,
    input  bm_pkg::t_mon_stat  i_stat,
    output logic               o_led,
    output logic               o_buzzer
);
    import bm_pkg::*;

    logic [BLINK_W-1:0] r_counter, n_counter;
    logic               r_bursting, n_bursting;
    logic [TOG_W-1:0]   r_toggles, n_toggles;
    logic               r_led, n_led;
    logic               r_buzzer, n_buzzer;

    logic [BLINK_W-1:0] w_cnt_inc;
    logic               w_buz_pre;
    logic [TOG_W-1:0]   w_tog_inc;
    logic               w_fire;
    logic               w_end;

    // A silenced alarm turns the buzzer off ahead of the sequencer
    assign w_cnt_inc = (r_counter == BLINK_MAX) ? r_counter : r_counter + BLINK_W'(1);
    assign w_buz_pre = i_stat.silence ? 1'b0 : r_buzzer;
    assign w_tog_inc = r_toggles + TOG_W'(1);
    assign w_fire    = r_bursting && (w_cnt_inc > BLINK_W'(i_cfg.toggle_ticks));
    assign w_end     = w_fire && (w_tog_inc == i_cfg.toggles_per_burst);

    // Sequencer next state
    always_comb begin
        n_counter  = w_cnt_inc;
        n_bursting = r_bursting;
        n_toggles  = r_toggles;
        n_led      = r_led;
        n_buzzer   = w_buz_pre;
        if (!r_bursting) begin
            if (w_cnt_inc > i_cfg.wait_ticks) begin
                n_counter  = '0;
                n_bursting = 1'b1;
            end
        end else if (w_fire) begin
            n_counter = '0;
            n_toggles = w_tog_inc;
            if (!i_stat.alarm) begin
                n_led = !r_led;
            end else begin
                n_buzzer = !w_buz_pre;
                n_led    = 1'b1;
            end
            if (w_end) begin
                if (!i_stat.alarm) begin
                    n_led = 1'b0;
                end else begin
                    n_buzzer = 1'b0;
                end
                n_toggles  = '0;
                n_bursting = 1'b0;
            end
        end
    end

    assign o_led    = n_led;
    assign o_buzzer = n_buzzer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_bursting <= 1'b0;
            r_toggles  <= '0;
            r_led      <= 1'b0;
            r_buzzer   <= 1'b0;
        end else if (i_step) begin
            r_counter  <= n_counter;
            r_bursting <= n_bursting;
            r_toggles  <= n_toggles;
            r_led      <= n_led;
            r_buzzer   <= n_buzzer;
        end
    end

    // Toggle count is zero whenever no burst runs
    a_idle_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_bursting |-> r_toggles == '0)
        else $error("toggle count nonzero while waiting");

    // A burst without alarm leaves the LED off
    a_end_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_end && !i_stat.alarm |=> !r_led)
        else $error("LED left on after burst");

    // Silencing the alarm leaves the buzzer off
    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_stat.silence |=> !r_buzzer)
        else $error("buzzer on after alarm cleared");

endmodule

@@ hw/rtl/battery_monitor_blink_alarm.sv @@
// Battery monitor with blink/alarm sequencer. Each transfer on i_tick is one
// 10 ms tick carrying the battery voltage in millivolts; each tick yields exactly
// one transfer on o_result with the LED and buzzer levels, the low-voltage flag,
// the latest 50-sample average and a flag marking the tick an average completed.
// A tick passes an input register, then combinational logic (sample sum, a
// reciprocal multiply for the average, threshold compare, blink counters) that
// updates the state and loads the output register. Sustained rate is one tick
// per clock while o_result is ready; the input side keeps taking ticks while
// a result waits, as long as the output register drains. Registers are written
// over the APB port at byte address 4*index; write only while no tick is in
// flight; the block does not check this. Reset restores the documented defaults.
module battery_monitor_blink_alarm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bm_tick_if.sink                     i_tick,
    bm_result_if.source                 o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bm_pkg::PADDR_W-1:0]  paddr,
    input  logic [bm_pkg::PDATA_W-1:0]  pwdata,
    output logic [bm_pkg::PDATA_W-1:0]  prdata,
    output logic                        pready
);
    import bm_pkg::*;

    t_cfg       w_cfg;
    t_mon_stat  w_stat;
    logic       w_led;
    logic       w_buzzer;
    logic       w_step;

    logic            r_in_valid;
    logic [MV_W-1:0] r_in_mv;

    logic            r_out_valid;
    logic            r_out_led;
    logic            r_out_buzzer;
    logic            r_out_low;
    logic [MV_W-1:0] r_out_avg;
    logic            r_out_ready;

    // Configuration registers
    bm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Tick advances when the input register holds one and the output can take it
    assign w_step       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_mv <= i_tick.battery_mv;
        end
    end

    // Averaging and alarm decision
    bm_monitor u_monitor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_mv    (r_in_mv),
        .i_cfg   (w_cfg),
        .o_stat  (w_stat)
    );

    // Blink sequencer
    bm_blink u_blink (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cfg    (w_cfg),
        .i_stat   (w_stat),
        .o_led    (w_led),
        .o_buzzer (w_buzzer)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_led    <= w_led;
            r_out_buzzer <= w_buzzer;
            r_out_low    <= w_stat.alarm;
            r_out_avg    <= w_stat.average_mv;
            r_out_ready  <= w_stat.avg_ready;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.led_on        = r_out_led;
    assign o_result.buzzer_on     = r_out_buzzer;
    assign o_result.low_voltage   = r_out_low;
    assign o_result.average_mv    = r_out_avg;
    assign o_result.average_ready = r_out_ready;

endmodule

@@ verif/battery_monitor_blink_alarm_test.sv @@
module battery_monitor_blink_alarm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bm_pkg::*;

    localparam int          MV_TOP        = 20000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          LONG_HOLD     = 250;
    localparam int          NOTE_LIMIT    = 40;
    localparam int          AVG_DIVISOR   = (SPA_CNT == 0) ? 1 : int'(SPA_CNT);
    localparam longint      RUN_LIMIT_NS  = 64'd10_000_000;

    // One result per tick: lamp, buzzer, alarm and averaging status
    typedef struct packed {
        logic            led_on;
        logic            buzzer_on;
        logic            low_voltage;
        logic [MV_W-1:0] average_mv;
        logic            average_ready;
    } t_tick_status;

    localparam t_tick_status ZERO_STATUS = '0;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_reg_idx           reg_idx;
        logic [PDATA_W-1:0] value;
        logic [MV_W-1:0]    mv;
        logic               typed;
        t_tick_status       want;
    } t_row;

    typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_RARE, SINK_PATTERN} t_sink_mode;

    // Directed part: reset behavior is all-zero, then short bursts and extreme settings
    localparam t_row DIRECTED [29] = '{
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd0,     1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd20000, 1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd16384, 1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd16383, 1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd10922, 1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd5461,  1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd9600,  1'b1, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd9599,  1'b1, ZERO_STATUS},
        '{ROW_WRITE, REG_WAIT_TICKS,        32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_WRITE, REG_TOGGLE_TICKS,      32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_WRITE, REG_TOGGLES_PER_BURST, 32'd2,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_WRITE, REG_SAMPLE_PERIOD,     32'd1,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_WRITE, REG_LOW_THRESHOLD,     32'd20000, 15'd0,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd20000, 1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd20000, 1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd19999, 1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd1,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd12345, 1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd8000,  1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd16384, 1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd4095,  1'b0, ZERO_STATUS},
        '{ROW_WRITE, REG_TOGGLES_PER_BURST, 32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_WRITE, REG_LOW_THRESHOLD,     32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd20000, 1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd0,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd7,     1'b0, ZERO_STATUS},
        '{ROW_TICK,  REG_LOW_THRESHOLD,     32'd0,     15'd20000, 1'b0, ZERO_STATUS}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bm_tick_if   tick_ch();
    bm_result_if result_ch();

    battery_monitor_blink_alarm u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the monitor state and its register settings
    t_cfg               cfg;
    logic [BLINK_W-1:0] m_blink;
    logic [DIV_W-1:0]   m_div;
    logic [CNT_W-1:0]   m_count;
    logic [SUM_W-1:0]   m_sum;
    logic [MV_W-1:0]    m_avg;
    logic               m_alarm;
    logic               m_bursting;
    logic [TOG_W-1:0]   m_toggles;
    logic               m_led;
    logic               m_buzz;

    t_tick_status due_status[$];

    int  mismatches    = 0;
    int  ticks_sent    = 0;
    int  results_seen  = 0;
    int  averages_done = 0;
    int  alarm_raises  = 0;
    int  bursts_begun  = 0;
    int  silenced      = 0;
    int  burst_left    = 0;
    bit  hold_off_req  = 1'b0;

    task automatic report_mismatch(input string note);
        mismatches++;
        if (mismatches <= NOTE_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, note);
        end
    endtask

    // Advance the monitor by one tick and return its outputs after the tick
    function automatic t_tick_status advance_monitor(input logic [MV_W-1:0] mv);
        t_tick_status st;
        logic [SUM_W:0] wide;
        st = '0;
        if (m_blink != BLINK_MAX) m_blink++;
        if (m_div != DIV_MAX) m_div++;

        // sampling and averaging
        if (m_div >= cfg.sample_period) begin
            m_div = '0;
            wide = {1'b0, m_sum} + mv;
            m_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
            m_count = m_count + 1'b1;
            if (m_count == SPA_CNT) begin
                m_avg = MV_W'(m_sum / AVG_DIVISOR);
                m_sum = '0;
                m_count = '0;
                st.average_ready = 1'b1;
                averages_done++;
                if (m_avg < cfg.low_threshold_mv) begin
                    if (!m_alarm) alarm_raises++;
                    m_alarm = 1'b1;
                end else if (m_alarm) begin
                    if (m_buzz) silenced++;
                    m_alarm = 1'b0;
                    m_buzz = 1'b0;
                end
            end
        end

        // blink sequencer: idle wait, then a burst of toggles
        if (!m_bursting) begin
            if (m_blink > cfg.wait_ticks) begin
                m_blink = '0;
                m_bursting = 1'b1;
                bursts_begun++;
            end
        end else if (m_blink > cfg.toggle_ticks) begin
            m_blink = '0;
            if (!m_alarm) begin
                m_led = ~m_led;
            end else begin
                m_buzz = ~m_buzz;
                m_led = 1'b1;
            end
            m_toggles = m_toggles + 1'b1;
            if (m_toggles == cfg.toggles_per_burst) begin
                if (!m_alarm) m_led = 1'b0;
                else m_buzz = 1'b0;
                m_toggles = '0;
                m_bursting = 1'b0;
            end
        end

        st.led_on      = m_led;
        st.buzzer_on   = m_buzz;
        st.low_voltage = m_alarm;
        st.average_mv  = m_avg;
        return st;
    endfunction

    // Offer one tick, wait for the transfer, then maybe pause between bursts
    task automatic send_tick(input logic [MV_W-1:0] mv, input logic typed,
                             input t_tick_status typed_want);
        t_tick_status predicted;
        int unsigned gap;
        tick_ch.valid      <= 1'b1;
        tick_ch.battery_mv <= mv;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        predicted = advance_monitor(mv);
        due_status.push_back(typed ? typed_want : predicted);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(100, 300);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 8);
            end
            if (gap != 0) begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Block is idle once every result is back and the pipe has drained
    task automatic settle_block();
        tick_ch.valid <= 1'b0;
        while (due_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then read the register back
    task automatic write_register(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_LOW_THRESHOLD:     cfg.low_threshold_mv  = value[MV_W-1:0];
            REG_SAMPLE_PERIOD:     cfg.sample_period     = value[DIV_W-1:0];
            REG_WAIT_TICKS:        cfg.wait_ticks        = value[BLINK_W-1:0];
            REG_TOGGLE_TICKS:      cfg.toggle_ticks      = value[TICK_W-1:0];
            REG_TOGGLES_PER_BURST: cfg.toggles_per_burst = value[TOG_W-1:0];
            default: ;
        endcase

        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        want = '0;
        case (idx)
            REG_LOW_THRESHOLD:     want[MV_W-1:0]    = cfg.low_threshold_mv;
            REG_SAMPLE_PERIOD:     want[DIV_W-1:0]   = cfg.sample_period;
            REG_WAIT_TICKS:        want[BLINK_W-1:0] = cfg.wait_ticks;
            REG_TOGGLE_TICKS:      want[TICK_W-1:0]  = cfg.toggle_ticks;
            REG_TOGGLES_PER_BURST: want[TOG_W-1:0]   = cfg.toggles_per_burst;
            default: ;
        endcase
        if (got !== want) begin
            report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                      idx.name(), got, want));
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result sink: stall modes change over the run; one long hold on request
    initial begin : result_sink
        int unsigned cyc;
        logic [7:0]  pattern;
        t_sink_mode  mode;
        cyc     = 0;
        pattern = 8'hFF;
        mode    = SINK_FREE;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (cyc % 48 == 0) begin
                    mode    = t_sink_mode'($urandom_range(0, 3));
                    pattern = 8'($urandom);
                    if (pattern == 8'h00) pattern = 8'h5A;
                end
                case (mode)
                    SINK_FREE:    result_ch.ready <= 1'b1;
                    SINK_COIN:    result_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_RARE:    result_ch.ready <= ($urandom_range(0, 7) != 0);
                    SINK_PATTERN: result_ch.ready <= pattern[cyc % 8];
                    default:      result_ch.ready <= 1'b1;
                endcase
                cyc++;
            end
        end
    end

    // Compare each result transfer with the oldest predicted status
    always @(posedge i_clk) begin : result_check
        t_tick_status want;
        t_tick_status got;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            got.led_on        = result_ch.led_on;
            got.buzzer_on     = result_ch.buzzer_on;
            got.low_voltage   = result_ch.low_voltage;
            got.average_mv    = result_ch.average_mv;
            got.average_ready = result_ch.average_ready;
            if (due_status.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = due_status.pop_front();
                if (got.led_on !== want.led_on)
                    report_mismatch($sformatf("result %0d led_on: got %b, expected %b",
                                              results_seen, got.led_on, want.led_on));
                if (got.buzzer_on !== want.buzzer_on)
                    report_mismatch($sformatf("result %0d buzzer_on: got %b, expected %b",
                                              results_seen, got.buzzer_on, want.buzzer_on));
                if (got.low_voltage !== want.low_voltage)
                    report_mismatch($sformatf("result %0d low_voltage: got %b, expected %b",
                                              results_seen, got.low_voltage, want.low_voltage));
                if (got.average_mv !== want.average_mv)
                    report_mismatch($sformatf("result %0d average_mv: got %0d, expected %0d",
                                              results_seen, got.average_mv, want.average_mv));
                if (got.average_ready !== want.average_ready)
                    report_mismatch($sformatf("result %0d average_ready: got %b, expected %b",
                                              results_seen, got.average_ready,
                                              want.average_ready));
            end
            results_seen++;
        end
    end

    // Stimulus
    initial begin : stimulus
        int   ph;
        int   n;
        int   v;
        int   level;
        int   level_left;
        int   spread;
        int   phase_len;
        int   settings_used;
        t_cfg next;
        t_row row;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.battery_mv = '0;

        cfg.low_threshold_mv  = RST_LOW_THRESHOLD;
        cfg.sample_period     = RST_SAMPLE_PERIOD;
        cfg.wait_ticks        = RST_WAIT_TICKS;
        cfg.toggle_ticks      = RST_TOGGLE_TICKS;
        cfg.toggles_per_burst = RST_TOGGLES_PER_BURST;
        m_blink    = '0;
        m_div      = '0;
        m_count    = '0;
        m_sum      = '0;
        m_avg      = '0;
        m_alarm    = 1'b0;
        m_bursting = 1'b0;
        m_toggles  = '0;
        m_led      = 1'b0;
        m_buzz     = 1'b0;
        level      = 9600;
        level_left = 0;
        spread     = 0;
        settings_used = 1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (n = 0; n < $size(DIRECTED); n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_WRITE) begin
                settle_block();
                write_register(row.reg_idx, row.value);
            end else begin
                send_tick(row.mv, row.typed, row.want);
            end
        end

        // random phases, each under its own register settings
        for (ph = 0; ph < 8; ph++) begin
            phase_len = 120;
            next.low_threshold_mv  = MV_W'($urandom_range(0, MV_TOP));
            next.sample_period     = DIV_W'($urandom_range(1, 3));
            next.wait_ticks        = BLINK_W'($urandom_range(0, 60));
            next.toggle_ticks      = TICK_W'($urandom_range(0, 12));
            next.toggles_per_burst = TOG_W'($urandom_range(1, 15));
            case (ph)
                0: begin
                    // power-on defaults: slow averaging, one long burst
                    next.low_threshold_mv  = RST_LOW_THRESHOLD;
                    next.sample_period     = RST_SAMPLE_PERIOD;
                    next.wait_ticks        = RST_WAIT_TICKS;
                    next.toggle_ticks      = RST_TOGGLE_TICKS;
                    next.toggles_per_burst = RST_TOGGLES_PER_BURST;
                    phase_len = 430;
                end
                1: begin
                    next.low_threshold_mv  = MV_W'(MV_TOP);
                    next.sample_period     = DIV_W'(1);
                    next.wait_ticks        = '0;
                    next.toggle_ticks      = '0;
                    next.toggles_per_burst = TOG_W'(1);
                end
                2: begin
                    next.sample_period     = DIV_W'(15);
                    next.toggles_per_burst = TOG_W'(15);
                    phase_len = 150;
                end
                3: begin
                    // burst never starts; idle counter runs into its ceiling
                    next.low_threshold_mv  = '0;
                    next.sample_period     = DIV_W'(1);
                    next.wait_ticks        = BLINK_W'(1023);
                    next.toggle_ticks      = TICK_W'(255);
                    next.toggles_per_burst = '0;
                    phase_len = 1030;
                end
                4: begin
                    // sample every tick, sixteen toggles per burst
                    next.sample_period     = '0;
                    next.wait_ticks        = BLINK_W'($urandom_range(0, 20));
                    next.toggle_ticks      = TICK_W'($urandom_range(0, 3));
                    next.toggles_per_burst = '0;
                    phase_len = 150;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        next.low_threshold_mv = MV_W'($urandom_range(9000, 10200));
                end
            endcase

            settle_block();
            write_register(REG_LOW_THRESHOLD, PDATA_W'(next.low_threshold_mv));
            write_register(REG_SAMPLE_PERIOD, PDATA_W'(next.sample_period));
            write_register(REG_WAIT_TICKS, PDATA_W'(next.wait_ticks));
            write_register(REG_TOGGLE_TICKS, PDATA_W'(next.toggle_ticks));
            write_register(REG_TOGGLES_PER_BURST, PDATA_W'(next.toggles_per_burst));
            settings_used++;

            for (n = 0; n < phase_len; n++) begin
                if (ph == 6 && n == 40) hold_off_req = 1'b1;

                // voltage holds a level for a while: rail, at threshold, or anywhere
                if (level_left == 0) begin
                    level_left = $urandom_range(20, 90);
                    case ($urandom_range(0, 7))
                        0:       level = 0;
                        1:       level = MV_TOP;
                        2, 3:    level = int'(cfg.low_threshold_mv);
                        default: level = $urandom_range(0, MV_TOP);
                    endcase
                    spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
                end
                level_left--;
                if ($urandom_range(0, 31) == 0) begin
                    v = $urandom_range(0, MV_TOP);
                end else begin
                    v = level + int'($urandom_range(0, 2 * spread)) - spread;
                    if (v < 0) v = 0;
                    if (v > MV_TOP) v = MV_TOP;
                end
                send_tick(MV_W'(v), 1'b0, ZERO_STATUS);
            end
        end

        // drain and finish
        tick_ch.valid <= 1'b0;
        for (n = 0; n < 5000 && due_status.size() != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_status.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_status.size()));
        end

        $display("Run: %0d ticks under %0d register settings, %0d results compared.",
                 ticks_sent, settings_used, results_seen);
        $display("Seen: %0d averages, %0d alarm raises, %0d bursts, %0d buzzer silencings.",
                 averages_done, alarm_raises, bursts_begun, silenced);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
